// ----- sv/opp_pkg.sv -----
// Package for the omnidirectional point projection: payload types and register indexes.
package opp_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int XI_FRAC    = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FOCAL_X   = 3'd0,
      CSR_FOCAL_Y   = 3'd1,
      CSR_CENTER_X  = 3'd2,
      CSR_CENTER_Y  = 3'd3,
      CSR_MIRROR_XI = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pixel_u;
      logic signed [31:0] pixel_v;
      logic               not_projectable;
   } rsp_type;

endpackage

// ----- sv/omni_point_projection.sv -----
// Omnidirectional point projection: fully pipelined norm, denominator, divide and saturate.
// Pipeline: stages A and B, the 32-stage square root, stages C, D and E, the two 65-stage
// restoring dividers and stage F lie between an accepted item and its rsp_valid strobe.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Reset (synchronous, active high) clears all valid bits and loads register defaults.
// Results are strobed for one cycle; the receiver cannot hold them off.
module omni_point_projection
   import opp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES  = 65;
   localparam int LATENCY     = SQRT_STAGES + DIV_STAGES + 6;

   typedef struct packed {
      logic [63:0] n;
      logic [33:0] rem;
      logic [31:0] root;
      req_type     pt;
   } sqrt_stage_type;

   typedef struct packed {
      logic [64:0] nq;
      logic [36:0] rem;
   } div_lane_type;

   typedef struct packed {
      div_lane_type lane_x;
      div_lane_type lane_y;
      logic [36:0]  den;
      logic         flag;
      logic         neg_x;
      logic         neg_y;
   } div_stage_type;

   // configuration
   logic [31:0] focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   logic [19:0] mirror_xi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff   <= 32'd13107200;
         focal_y_ff   <= 32'd13107200;
         center_x_ff  <= 32'd13107200;
         center_y_ff  <= 32'd13107200;
         mirror_xi_ff <= 20'd65536;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_FOCAL_X:   focal_x_ff   <= csr_wdata;
            CSR_FOCAL_Y:   focal_y_ff   <= csr_wdata;
            CSR_CENTER_X:  center_x_ff  <= csr_wdata;
            CSR_CENTER_Y:  center_y_ff  <= csr_wdata;
            CSR_MIRROR_XI: mirror_xi_ff <= csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

   function automatic sqrt_stage_type sqrt_step(input sqrt_stage_type s);
      sqrt_stage_type r;
      logic [35:0]    rem_sh;
      logic [35:0]    trial;
      r      = s;
      rem_sh = {s.rem, s.n[63:62]};
      trial  = {2'b00, s.root, 2'b01};
      r.n    = {s.n[61:0], 2'b00};
      if (rem_sh >= trial) begin
         r.rem  = 34'(rem_sh - trial);
         r.root = {s.root[30:0], 1'b1};
      end else begin
         r.rem  = rem_sh[33:0];
         r.root = {s.root[30:0], 1'b0};
      end
      return r;
   endfunction

   function automatic div_lane_type div_step(input div_lane_type l, input logic [36:0] den);
      div_lane_type r;
      logic [37:0]  rem_sh;
      rem_sh = {l.rem, l.nq[64]};
      r.nq   = {l.nq[63:0], 1'b0};
      if (rem_sh >= {1'b0, den}) begin
         r.rem   = 37'(rem_sh - {1'b0, den});
         r.nq[0] = 1'b1;
      end else begin
         r.rem = rem_sh[36:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] finish_axis(input logic [64:0] q, input logic neg,
                                               input logic [31:0] center);
      logic [33:0]        cap;
      logic signed [35:0] mag;
      logic signed [35:0] sum;
      cap = (q > 65'h2_0000_0000) ? 34'h2_0000_0000 : q[33:0];
      mag = $signed({2'b00, cap});
      sum = (neg ? -mag : mag) + $signed({{4{center[31]}}, center});
      if (sum > $signed(36'h0_7FFF_FFFF)) begin
         return 32'h7FFF_FFFF;
      end else if (sum < $signed(36'hF_8000_0000)) begin
         return 32'h8000_0000;
      end
      return sum[31:0];
   endfunction

   // stage A: squares
   logic        a_vld_ff;
   req_type     a_pt_ff;
   logic [63:0] a_sqx_ff, a_sqy_ff, a_sqz_ff;
   // stage B: sum of squares
   logic        b_vld_ff;
   req_type     b_pt_ff;
   logic [63:0] b_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start;
         b_vld_ff <= a_vld_ff;
      end
      a_pt_ff  <= req_data;
      a_sqx_ff <= mag32(req_data.point_x) * mag32(req_data.point_x);
      a_sqy_ff <= mag32(req_data.point_y) * mag32(req_data.point_y);
      a_sqz_ff <= mag32(req_data.point_z) * mag32(req_data.point_z);
      b_pt_ff  <= a_pt_ff;
      b_sum_ff <= a_sqx_ff + a_sqy_ff + a_sqz_ff;
   end

   // square root, one result bit per stage
   logic           sq_vld_ff [SQRT_STAGES];
   sqrt_stage_type sq_ff     [SQRT_STAGES];
   sqrt_stage_type sq_init;

   always_comb begin
      sq_init.n    = b_sum_ff;
      sq_init.rem  = '0;
      sq_init.root = '0;
      sq_init.pt   = b_pt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else begin
         sq_vld_ff[0] <= b_vld_ff;
      end
      sq_ff[0] <= sqrt_step(sq_init);
   end

   for (genvar i = 1; i < SQRT_STAGES; i++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[i] <= 1'b0;
         end else begin
            sq_vld_ff[i] <= sq_vld_ff[i-1];
         end
         sq_ff[i] <= sqrt_step(sq_ff[i-1]);
      end
   end

   // stage C: mirror term; stage D: denominator and numerators; stage E: divider setup
   logic               c_vld_ff, d_vld_ff;
   req_type            c_pt_ff;
   logic [51:0]        c_term_ff;
   logic signed [37:0] d_den_ff;
   logic [63:0]        d_num_x_ff, d_num_y_ff;
   logic               d_neg_x_ff, d_neg_y_ff;
   div_stage_type      dv_init;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= sq_vld_ff[SQRT_STAGES-1];
         d_vld_ff <= c_vld_ff;
      end
      c_pt_ff    <= sq_ff[SQRT_STAGES-1].pt;
      c_term_ff  <= mirror_xi_ff * sq_ff[SQRT_STAGES-1].root;
      d_den_ff   <= $signed({{6{c_pt_ff.point_z[31]}}, c_pt_ff.point_z})
                    + $signed({2'b00, c_term_ff[51:XI_FRAC]});
      d_num_x_ff <= focal_x_ff * mag32(c_pt_ff.point_x);
      d_num_y_ff <= focal_y_ff * mag32(c_pt_ff.point_y);
      d_neg_x_ff <= c_pt_ff.point_x[31];
      d_neg_y_ff <= c_pt_ff.point_y[31];
   end

   always_comb begin
      dv_init.den        = d_den_ff[36:0];
      dv_init.flag       = d_den_ff[37] || (d_den_ff == '0);
      dv_init.neg_x      = d_neg_x_ff;
      dv_init.neg_y      = d_neg_y_ff;
      // rounding: add half the denominator before dividing
      dv_init.lane_x.nq  = {1'b0, d_num_x_ff} + {29'd0, d_den_ff[36:1]};
      dv_init.lane_x.rem = '0;
      dv_init.lane_y.nq  = {1'b0, d_num_y_ff} + {29'd0, d_den_ff[36:1]};
      dv_init.lane_y.rem = '0;
   end

   logic          e_vld_ff;
   div_stage_type e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= d_vld_ff;
      end
      e_ff <= dv_init;
   end

   // restoring dividers, one quotient bit per stage, both axes side by side
   logic          dv_vld_ff [DIV_STAGES];
   div_stage_type dv_ff     [DIV_STAGES];

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      div_stage_type prev;
      logic          prev_vld;
      if (i == 0) begin : g_first
         assign prev     = e_ff;
         assign prev_vld = e_vld_ff;
      end else begin : g_next
         assign prev     = dv_ff[i-1];
         assign prev_vld = dv_vld_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[i] <= 1'b0;
         end else begin
            dv_vld_ff[i] <= prev_vld;
         end
         dv_ff[i].den    <= prev.den;
         dv_ff[i].flag   <= prev.flag;
         dv_ff[i].neg_x  <= prev.neg_x;
         dv_ff[i].neg_y  <= prev.neg_y;
         dv_ff[i].lane_x <= div_step(prev.lane_x, prev.den);
         dv_ff[i].lane_y <= div_step(prev.lane_y, prev.den);
      end
   end

   // stage F: zero the pixels of unprojectable items, else clamp, add center, saturate
   logic    f_vld_ff;
   rsp_type f_rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= dv_vld_ff[DIV_STAGES-1];
      end
      if (dv_ff[DIV_STAGES-1].flag) begin
         f_rsp_ff.pixel_u <= '0;
         f_rsp_ff.pixel_v <= '0;
      end else begin
         f_rsp_ff.pixel_u <= finish_axis(dv_ff[DIV_STAGES-1].lane_x.nq,
                                         dv_ff[DIV_STAGES-1].neg_x, center_x_ff);
         f_rsp_ff.pixel_v <= finish_axis(dv_ff[DIV_STAGES-1].lane_y.nq,
                                         dv_ff[DIV_STAGES-1].neg_y, center_y_ff);
      end
      f_rsp_ff.not_projectable <= dv_ff[DIV_STAGES-1].flag;
   end

   assign busy      = 1'b0;
   assign rsp_valid = f_vld_ff;
   assign rsp_data  = f_rsp_ff;

   // every accepted item comes out after the fixed latency
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("item lost in pipeline");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without item");

   a_flag_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.not_projectable) |->
         (rsp_data.pixel_u == '0 && rsp_data.pixel_v == '0))
      else $error("unprojectable item with nonzero pixel");

endmodule

// ----- tb/opp_checker.sv -----
// Checker for the omnidirectional point projection: predicts pixels and compares results.
`timescale 1ns / 1ps
module opp_checker
   import opp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count
);

   logic [31:0] focal_x, focal_y;
   logic signed [31:0] center_x, center_y;
   logic [19:0] mirror_xi;
   rsp_type expected_pixels[$];

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [31:0] axis_pixel(logic [31:0] f,
         logic signed [63:0] c, logic [63:0] den, logic signed [31:0] center);
      logic [63:0] mag, num, q;
      logic signed [63:0] sq, sum;
      mag = c < 0 ? -c : c;
      num = f * mag;
      q = (num + den / 2) / den;
      if (q > (64'd1 << 33)) q = 64'd1 << 33;
      sq = c < 0 ? -$signed(q) : $signed(q);
      sum = sq + center;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      return sum[31:0];
   endfunction

   function automatic rsp_type project_point(req_type p);
      logic signed [63:0] x, y, z, den;
      logic [63:0] ax, ay, az, nrm, term;
      rsp_type r;
      x = p.point_x; y = p.point_y; z = p.point_z;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      az = z < 0 ? -z : z;
      nrm = int_sqrt(ax * ax + ay * ay + az * az);
      term = (mirror_xi * nrm) >> XI_FRAC;
      den = z + $signed(term);
      r = '0;
      if (den <= 0) begin
         r.not_projectable = 1'b1;
      end else begin
         r.pixel_u = axis_pixel(focal_x, x, den, center_x);
         r.pixel_v = axis_pixel(focal_y, y, den, center_y);
      end
      return r;
   endfunction

   assign pending_count = expected_pixels.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         focal_x <= 32'd13107200;
         focal_y <= 32'd13107200;
         center_x <= 32'sd13107200;
         center_y <= 32'sd13107200;
         mirror_xi <= 20'd65536;
         fail_count <= 0;
         expected_pixels.delete();
      end else begin
         if (start && !busy) expected_pixels.push_back(project_point(req_data));
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected item %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_pixels.pop_front();
               if (want !== rsp_data) begin
                  $display("%0t: mismatch expected u=%h v=%h np=%b actual u=%h v=%h np=%b",
                     $time, want.pixel_u, want.pixel_v, want.not_projectable,
                     rsp_data.pixel_u, rsp_data.pixel_v, rsp_data.not_projectable);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_FOCAL_X:   focal_x <= csr_wdata;
               CSR_FOCAL_Y:   focal_y <= csr_wdata;
               CSR_CENTER_X:  center_x <= csr_wdata;
               CSR_CENTER_Y:  center_y <= csr_wdata;
               CSR_MIRROR_XI: mirror_xi <= csr_wdata[19:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ----- tb/tb_omni_point_projection.sv -----
// Testbench top for the omnidirectional point projection: stimulus and verdict.
`timescale 1ns / 1ps
module tb_omni_point_projection;
   import opp_pkg::*;

   localparam int LATENCY = 103;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 0, reset = 1, start = 0, busy, rsp_valid, csr_we = 0;
   req_type req_data = '0;
   rsp_type rsp_data;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int fail_count, pending_count, idle_cycles;
   bit finished = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   omni_point_projection dut (.*);
   opp_checker checker_i (.*);

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!finished && idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1; csr_addr <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic drain;
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   // random idle gap before each item when gaps is set, none in some stretches
   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit gaps);
      int n;
      n = gaps ? $urandom_range(0, 15) : 0;
      if (n > 0) begin
         start <= 0;
         repeat (n) @(negedge clock);
      end
      req_data <= '{x, y, z};
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic end_burst;
      start <= 0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 2000000)) - 1000000;
         2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return $signed($urandom_range(0, 20000000)) - 10000000;
      endcase
   endfunction

   logic [31:0] edges[6] = '{32'h0, 32'h1, 32'hffffffff, 32'h7fffffff, 32'h80000000,
                             32'h00010000};

   initial begin
      bit gaps;
      repeat (9) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: extremes, origin, behind camera, tiny denominator
      for (int i = 0; i < 6; i++) send_point(edges[i], edges[5 - i], edges[(i + 2) % 6], 0);
      send_point(0, 0, 0, 0);
      send_point(32'h00010000, 32'h00010000, 32'hffff0000, 0);
      send_point(32'h7fffffff, 32'h80000000, 32'h1, 0);
      send_point(32'h1, 32'h1, 32'h1, 0);
      send_point(32'h00050000, 32'hfffb0000, 32'h000a0000, 0);
      end_burst();
      drain();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_MIRROR_XI, 0);
               write_csr(CSR_FOCAL_X, 32'hffffffff);
               write_csr(CSR_FOCAL_Y, 0);
            end
            1: begin
               write_csr(CSR_MIRROR_XI, 32'hfffff);
               write_csr(CSR_CENTER_X, 32'h7fffffff);
               write_csr(CSR_CENTER_Y, 32'h80000000);
            end
            2: begin
               write_csr(CSR_FOCAL_X, 0);
               write_csr(CSR_FOCAL_Y, 32'hffffffff);
               write_csr(CSR_CENTER_X, 32'h80000000);
               write_csr(CSR_CENTER_Y, 32'h7fffffff);
            end
            default: begin
               write_csr(CSR_FOCAL_X, $urandom);
               write_csr(CSR_FOCAL_Y, $urandom);
               write_csr(CSR_CENTER_X, $urandom);
               write_csr(CSR_CENTER_Y, $urandom);
               write_csr(CSR_MIRROR_XI, $urandom);
            end
         endcase
         for (int i = 0; i < 140; i++) begin
            gaps = (i / 35) % 2;
            send_point(rand_coord(), rand_coord(), rand_coord(), gaps);
         end
         end_burst();
         drain();
      end
      finished = 1;
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
